// ----- hdl/hsi_pkg.sv -----
`timescale 1ns / 1ps

package hsi_pkg;

  // Data path sizes
  localparam int SAMPLE_W  = 16;
  localparam int POS_FRAC  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TENSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS    = 1'b1;

  // Tangent weights: (1 +/- bias) * (1 - tension) / 2 in Q.14
  localparam int WOP_W     = CFG_W + 1;
  localparam int WPROD_W   = 2 * WOP_W;
  localparam int WGT_SHIFT = 15;
  localparam int WGT_W     = 18;
  localparam logic signed [WOP_W-1:0]   ONE_Q14 = WOP_W'(16384);
  localparam logic signed [WPROD_W-1:0] WGT_HALF = WPROD_W'(1) << (WGT_SHIFT - 1);

  // Tangent precision
  localparam int TAN_LIMIT = 60 - SAMPLE_W - POS_FRAC;
  localparam int TAN_FRAC  = (TAN_LIMIT < 14) ? TAN_LIMIT : 14;
  localparam int TAN_SHIFT = 14 - TAN_FRAC;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int TPROD_W   = DIFF_W + WGT_W;
  localparam int TAN_W     = TPROD_W + 1;
  localparam logic signed [TAN_W-1:0] TAN_HALF =
    (TAN_SHIFT == 0) ? '0 : (TAN_W'(1) << (TAN_SHIFT - 1));

  // Position powers and basis coefficients
  localparam int PSQ_W  = 2 * POS_FRAC;
  localparam int COEF_W = POS_FRAC + 3;
  localparam logic [PSQ_W-1:0] POS_HALF = PSQ_W'(1) << (POS_FRAC - 1);
  localparam logic signed [COEF_W-1:0] POS_ONE = COEF_W'(1) << POS_FRAC;

  // Tangent split for the basis-by-tangent products
  localparam int TAN_SPLIT = 18;
  localparam int THI_W     = TAN_W - TAN_SPLIT;
  localparam int PLO_W     = COEF_W + TAN_SPLIT + 1;
  localparam int PHI_W     = COEF_W + THI_W;
  localparam int APROD_W   = COEF_W + SAMPLE_W;

  // Accumulation and output rounding
  localparam int LIN_W     = APROD_W + 1;
  localparam int T_W       = COEF_W + TAN_W + 2;
  localparam int SUM_W     = (((LIN_W + TAN_FRAC) > T_W) ? (LIN_W + TAN_FRAC) : T_W) + 2;
  localparam int OUT_SHIFT = POS_FRAC + TAN_FRAC;
  localparam int R_W       = SUM_W - OUT_SHIFT;
  localparam logic signed [SUM_W-1:0] OUT_HALF = SUM_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [R_W-1:0]   SAT_HI = R_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [R_W-1:0]   SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_before;
    logic signed [SAMPLE_W-1:0] sample_start;
    logic signed [SAMPLE_W-1:0] sample_end;
    logic signed [SAMPLE_W-1:0] sample_after;
    logic        [POS_FRAC-1:0] position;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] interpolated;
    logic                       clipped;
  } out_res_t;

endpackage

// ----- hdl/hermite_spline_interpolator.sv -----
`timescale 1ns / 1ps

// Cubic Hermite interpolator with tension and bias.
// Request channel: drive in_data (four neighboring samples and a Q0.16
// position between sample_start and sample_end) and pulse start. A request
// is taken on every clock edge where start is high and busy is low; busy is
// never raised, so a new request may enter on every cycle.
// Result channel: out_valid is high for exactly one cycle with out_data
// (rounded, saturated sample plus the clipped flag). Results come out in
// request order. Throughput is one request per clock through six register
// stages (differences and p*p, p2*p and tangent products, tangents and basis
// coefficients, split basis products, partial sums, final sum with rounding
// and saturation). The receiver cannot hold results off: results are
// simply presented.
// Configuration: cfg_we with cfg_index selects tension or bias (Q1.14). Write
// only while no request is in flight. Weights are registered from them.
// Reset (rst_n low, synchronous) clears tension, bias and all valid bits; no
// result is presented out of reset.
module hermite_spline_interpolator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  hsi_pkg::in_req_t                 in_data,
  output logic                             out_valid,
  output hsi_pkg::out_res_t                out_data,
  input  logic                             cfg_we,
  input  logic [hsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsi_pkg::CFG_W-1:0]        cfg_wdata
);
  import hsi_pkg::*;

  // Configuration registers
  logic signed [CFG_W-1:0] tension_r, bias_r;

  // Tangent weights, recomputed every cycle from the registers
  logic signed [WOP_W-1:0]   tw, bp, bm;
  logic signed [WPROD_W-1:0] wprod_p, wprod_m, wsum_p, wsum_m;
  logic signed [WGT_W-1:0]   wp_r, wm_r;

  // Stage 1: differences and p*p
  logic                       v1_r;
  logic signed [DIFF_W-1:0]   d10_1_r, d21_1_r, d32_1_r;
  logic signed [SAMPLE_W-1:0] s1_1_r, s2_1_r;
  logic        [POS_FRAC-1:0] p_1_r;
  logic        [PSQ_W-1:0]    pp_1_r;

  // Stage 2: p2, p2*p, tangent products
  logic                       v2_r;
  logic        [PSQ_W-1:0]    p2_sum;
  logic        [POS_FRAC-1:0] p2_nxt;
  logic        [POS_FRAC-1:0] p_2_r, p2_2_r;
  logic        [PSQ_W-1:0]    ppp_2_r;
  logic signed [TPROD_W-1:0]  t0a_2_r, t0b_2_r, t1a_2_r, t1b_2_r;
  logic signed [SAMPLE_W-1:0] s1_2_r, s2_2_r;

  // Stage 3: tangents and basis coefficients
  logic                       v3_r;
  logic signed [TAN_W-1:0]    m0_sum, m1_sum;
  logic        [PSQ_W-1:0]    p3_sum;
  logic        [POS_FRAC-1:0] p3;
  logic signed [COEF_W-1:0]   pe, p2e, p3e;
  logic signed [COEF_W-1:0]   a0_nxt, a1_nxt, a2_nxt, a3_nxt;
  logic signed [TAN_W-1:0]    m0_3_r, m1_3_r;
  logic signed [COEF_W-1:0]   a0_3_r, a1_3_r, a2_3_r, a3_3_r;
  logic signed [SAMPLE_W-1:0] s1_3_r, s2_3_r;

  // Stage 4: partial products
  logic                       v4_r;
  logic signed [TAN_SPLIT:0]  m0_lo, m1_lo;
  logic signed [THI_W-1:0]    m0_hi, m1_hi;
  logic signed [PLO_W-1:0]    q0lo_4_r, q1lo_4_r;
  logic signed [PHI_W-1:0]    q0hi_4_r, q1hi_4_r;
  logic signed [APROD_W-1:0]  l0_4_r, l3_4_r;

  // Stage 5: partial sums
  logic                       v5_r;
  logic signed [T_W-1:0]      t_5_r;
  logic signed [LIN_W-1:0]    lin_5_r;

  // Stage 6: final sum, round, saturate
  logic signed [SUM_W-1:0]    sum;
  logic signed [R_W-1:0]      rnd_val;
  out_res_t                   res_nxt;
  logic                       v6_r;
  out_res_t                   res_r;

  // pipeline takes a request every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r <= '0;
      bias_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TENSION: tension_r <= cfg_wdata;
        REG_BIAS:    bias_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // wp = (1+bias)(1-tension)/2, wm = (1-bias)(1-tension)/2, round half up
  always_comb begin
    tw      = ONE_Q14 - $signed({tension_r[CFG_W-1], tension_r});
    bp      = ONE_Q14 + $signed({bias_r[CFG_W-1], bias_r});
    bm      = ONE_Q14 - $signed({bias_r[CFG_W-1], bias_r});
    wprod_p = bp * tw;
    wprod_m = bm * tw;
    wsum_p  = wprod_p + WGT_HALF;
    wsum_m  = wprod_m + WGT_HALF;
  end

  always_ff @(posedge clk) begin
    wp_r <= WGT_W'(wsum_p >>> WGT_SHIFT);
    wm_r <= WGT_W'(wsum_m >>> WGT_SHIFT);
  end

  // Stage 1
  always_ff @(posedge clk) begin
    d10_1_r <= $signed({in_data.sample_start[SAMPLE_W-1], in_data.sample_start})
             - $signed({in_data.sample_before[SAMPLE_W-1], in_data.sample_before});
    d21_1_r <= $signed({in_data.sample_end[SAMPLE_W-1], in_data.sample_end})
             - $signed({in_data.sample_start[SAMPLE_W-1], in_data.sample_start});
    d32_1_r <= $signed({in_data.sample_after[SAMPLE_W-1], in_data.sample_after})
             - $signed({in_data.sample_end[SAMPLE_W-1], in_data.sample_end});
    s1_1_r  <= in_data.sample_start;
    s2_1_r  <= in_data.sample_end;
    p_1_r   <= in_data.position;
    pp_1_r  <= in_data.position * in_data.position;
  end

  // Stage 2
  always_comb begin
    p2_sum = pp_1_r + POS_HALF;
    p2_nxt = p2_sum[PSQ_W-1:POS_FRAC];
  end

  always_ff @(posedge clk) begin
    p_2_r   <= p_1_r;
    p2_2_r  <= p2_nxt;
    ppp_2_r <= p2_nxt * p_1_r;
    t0a_2_r <= d10_1_r * wp_r;
    t0b_2_r <= d21_1_r * wm_r;
    t1a_2_r <= d21_1_r * wp_r;
    t1b_2_r <= d32_1_r * wm_r;
    s1_2_r  <= s1_1_r;
    s2_2_r  <= s2_1_r;
  end

  // Stage 3
  always_comb begin
    m0_sum = t0a_2_r + t0b_2_r + TAN_HALF;
    m1_sum = t1a_2_r + t1b_2_r + TAN_HALF;
    p3_sum = ppp_2_r + POS_HALF;
    p3     = p3_sum[PSQ_W-1:POS_FRAC];
    pe     = $signed({{(COEF_W-POS_FRAC){1'b0}}, p_2_r});
    p2e    = $signed({{(COEF_W-POS_FRAC){1'b0}}, p2_2_r});
    p3e    = $signed({{(COEF_W-POS_FRAC){1'b0}}, p3});
    a0_nxt = (p3e <<< 1) - (p2e <<< 1) - p2e + POS_ONE;
    a1_nxt = p3e - (p2e <<< 1) + pe;
    a2_nxt = p3e - p2e;
    a3_nxt = (p2e <<< 1) + p2e - (p3e <<< 1);
  end

  always_ff @(posedge clk) begin
    m0_3_r <= m0_sum >>> TAN_SHIFT;
    m1_3_r <= m1_sum >>> TAN_SHIFT;
    a0_3_r <= a0_nxt;
    a1_3_r <= a1_nxt;
    a2_3_r <= a2_nxt;
    a3_3_r <= a3_nxt;
    s1_3_r <= s1_2_r;
    s2_3_r <= s2_2_r;
  end

  // Stage 4: tangent split into unsigned low and signed high halves
  always_comb begin
    m0_lo = $signed({1'b0, m0_3_r[TAN_SPLIT-1:0]});
    m1_lo = $signed({1'b0, m1_3_r[TAN_SPLIT-1:0]});
    m0_hi = m0_3_r[TAN_W-1:TAN_SPLIT];
    m1_hi = m1_3_r[TAN_W-1:TAN_SPLIT];
  end

  always_ff @(posedge clk) begin
    q0lo_4_r <= a1_3_r * m0_lo;
    q0hi_4_r <= a1_3_r * m0_hi;
    q1lo_4_r <= a2_3_r * m1_lo;
    q1hi_4_r <= a2_3_r * m1_hi;
    l0_4_r   <= a0_3_r * s1_3_r;
    l3_4_r   <= a3_3_r * s2_3_r;
  end

  // Stage 5
  always_ff @(posedge clk) begin
    t_5_r <= (T_W'(q0hi_4_r) <<< TAN_SPLIT) + T_W'(q0lo_4_r)
           + (T_W'(q1hi_4_r) <<< TAN_SPLIT) + T_W'(q1lo_4_r);
    lin_5_r <= LIN_W'(l0_4_r) + LIN_W'(l3_4_r);
  end

  // Stage 6
  always_comb begin
    sum     = (SUM_W'(lin_5_r) <<< TAN_FRAC) + SUM_W'(t_5_r) + OUT_HALF;
    rnd_val = R_W'(sum >>> OUT_SHIFT);
    if (rnd_val > SAT_HI) begin
      res_nxt.interpolated = SAT_HI[SAMPLE_W-1:0];
      res_nxt.clipped      = 1'b1;
    end else if (rnd_val < SAT_LO) begin
      res_nxt.interpolated = SAT_LO[SAMPLE_W-1:0];
      res_nxt.clipped      = 1'b1;
    end else begin
      res_nxt.interpolated = rnd_val[SAMPLE_W-1:0];
      res_nxt.clipped      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Valid bits ride alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = res_r;

endmodule
